[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the congestion window core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked check that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lcw_pkg.sv]
// ---------------------------------------------------------------------------
// lcw_pkg
// Types, widths and codes shared by the LEDBAT congestion window core.
// ---------------------------------------------------------------------------
package lcw_pkg;

   localparam int WINDOW_BITS_DEF = 32;
   localparam int FIELD_BITS      = 32;
   localparam int ACC_BITS        = 32;
   localparam int MSS_BITS        = 16;
   localparam int DELAY_BITS      = 16;
   localparam int RTT_BITS        = 16;
   localparam int SEGS_BITS       = 8;
   localparam int SHIFT_BITS      = 3;
   localparam int FLIGHT_BITS     = 31;
   localparam int ACTION_BITS     = 3;
   localparam int INCR_BITS       = MSS_BITS + 1;           // up to two segments
   localparam int SMALL_PROD_BITS = SEGS_BITS + MSS_BITS;   // segs * mss
   localparam int CAP_BITS        = FLIGHT_BITS + 7 + 1;    // flight << 7 plus add
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;
   localparam int MIN_HALVE_SEGS  = 2;

   localparam logic [DELAY_BITS-1:0] TARGET_DELAY_RST = 16'd100;
   localparam logic [SEGS_BITS-1:0]  ALLOWED_INC_RST  = 8'd8;
   localparam logic [SHIFT_BITS-1:0] TETHER_SHIFT_RST = 3'd1;
   localparam logic [SEGS_BITS-1:0]  INIT_WINDOW_RST  = 8'd2;
   localparam logic [MSS_BITS-1:0]   MSS_RST          = 16'd1448;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_INIT           = 3'd0,
      ACT_ACK            = 3'd1,
      ACT_FAST_ACK       = 3'd2,
      ACT_ENTER_RECOVERY = 3'd3,
      ACT_EXIT_RECOVERY  = 3'd4,
      ACT_IDLE_RESTART   = 3'd5,
      ACT_TIMEOUT        = 3'd6,
      ACT_SWITCH         = 3'd7
   } lcw_action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TARGET_DELAY = 3'd0,
      CSR_ALLOWED_INC  = 3'd1,
      CSR_TETHER_SHIFT = 3'd2,
      CSR_INIT_WINDOW  = 3'd3,
      CSR_MSS          = 3'd4,
      CSR_ABC_DOUBLE   = 3'd5
   } lcw_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_EXEC,
      ST_FLOOR_MUL,
      ST_FLOOR_APPLY,
      ST_CAP_MUL,
      ST_GROW,
      ST_CAP,
      ST_DIV_SET,
      ST_DIV_WAIT,
      ST_SEG_MUL,
      ST_SEG_APPLY,
      ST_DONE
   } lcw_state_type;

endpackage

[rtl/ledbat_congestion_window_core.sv]
// ---------------------------------------------------------------------------
// ledbat_congestion_window_core
// Congestion state of one background TCP connection under LEDBAT.
// ---------------------------------------------------------------------------
// Usage:
//   One event request enters on req_* (valid/ready). The core updates the
//   window, the standard threshold, the background threshold and the acked
//   byte count, then posts one response on rsp_* with the three values.
//   req_ready is high only while the sequencer is idle; one request is
//   worked on at a time.
//   Init and idle restart pass through the floor multiply, exit recovery
//   through the execute step alone; acks that grow the window also use the
//   shared multiplier, delay check and tether cap. Enter recovery, timeout
//   (when established) and switch wait on the divider by segment size that
//   retires one quotient bit per cycle.
//   The response sits in an output register; the next request is accepted
//   while it waits, and a finished result only waits in the last step if
//   the previous response is still not taken.
//   Reset (synchronous, active high) restores the default settings, zeroes
//   window, background threshold and acked count, and sets the standard
//   threshold to all ones. csr_* writes are taken at any edge with
//   csr_wr_en high and must only happen while the core is idle.
// ---------------------------------------------------------------------------
module ledbat_congestion_window_core #(
   parameter int WINDOW_BITS = lcw_pkg::WINDOW_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lcw_pkg::ACTION_BITS-1:0]     req_action,
   input  logic [lcw_pkg::FIELD_BITS-1:0]      req_bytes_acked,
   input  logic [lcw_pkg::RTT_BITS-1:0]        req_base_rtt,
   input  logic [lcw_pkg::RTT_BITS-1:0]        req_current_rtt,
   input  logic [lcw_pkg::FLIGHT_BITS-1:0]     req_bytes_in_flight,
   input  logic [lcw_pkg::FIELD_BITS-1:0]      req_peer_window,
   input  logic                                req_at_send_max,
   input  logic                                req_established,
   input  logic [lcw_pkg::FIELD_BITS-1:0]      req_threshold_in,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lcw_pkg::FIELD_BITS-1:0]      rsp_window,
   output logic [lcw_pkg::FIELD_BITS-1:0]      rsp_threshold,
   output logic [lcw_pkg::FIELD_BITS-1:0]      rsp_background_threshold,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [lcw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lcw_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int W         = WINDOW_BITS;
   localparam int PROD_BITS = W + lcw_pkg::MSS_BITS;
   localparam int SUM_BITS  = W + 2;
   localparam int INCR_BITS = lcw_pkg::INCR_BITS;
   localparam int CAP_BITS  = lcw_pkg::CAP_BITS;
   localparam logic [W-1:0] WIN_MAX = {W{1'b1}};

   // configuration registers
   logic [lcw_pkg::DELAY_BITS-1:0] cfg_target_ff;
   logic [lcw_pkg::SEGS_BITS-1:0]  cfg_allowed_ff;
   logic [lcw_pkg::SHIFT_BITS-1:0] cfg_shift_ff;
   logic [lcw_pkg::SEGS_BITS-1:0]  cfg_init_ff;
   logic [lcw_pkg::MSS_BITS-1:0]   cfg_mss_ff;
   logic                           cfg_abc_ff;

   // latched request
   lcw_pkg::lcw_action_type        act_ff;
   logic [lcw_pkg::FIELD_BITS-1:0] acked_ff;
   logic [lcw_pkg::RTT_BITS-1:0]   base_ff;
   logic [lcw_pkg::RTT_BITS-1:0]   cur_ff;
   logic [lcw_pkg::FLIGHT_BITS-1:0] flight_ff;
   logic [lcw_pkg::FIELD_BITS-1:0] peer_ff;
   logic                           atmax_ff;
   logic                           estab_ff;
   logic [W-1:0]                   thr_ff;

   // connection state
   lcw_pkg::lcw_state_type         state_ff, state_in;
   logic [W-1:0]                   cong_ff, cong_in;
   logic [W-1:0]                   slow_ff, slow_in;
   logic [W-1:0]                   bg_ff, bg_in;
   logic [lcw_pkg::ACC_BITS-1:0]   acc_ff, acc_in;

   // working registers
   logic [INCR_BITS-1:0]           incr_ff, incr_in;
   logic [W-1:0]                   floor_ff, floor_in;
   logic [CAP_BITS-1:0]            cap_ff, cap_in;
   logic [PROD_BITS-1:0]           prod_ff, prod_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                   rsp_win_ff, rsp_win_in;
   logic [W-1:0]                   rsp_slow_ff, rsp_slow_in;
   logic [W-1:0]                   rsp_bg_ff, rsp_bg_in;

   // control
   logic                           div_start;
   logic                           div_done;
   logic [W-1:0]                   div_quot;
   logic [W-1:0]                   div_dividend;
   logic                           rsp_load;
   logic                           exec_grow;

   // datapath helpers
   logic [lcw_pkg::MSS_BITS-1:0]   mss;
   logic [lcw_pkg::FIELD_BITS:0]   thr_ext;
   logic [W-1:0]                   thr_sat;
   logic [W-1:0]                   prod_sat;
   logic [W-1:0]                   mul_a;
   logic [W-1:0]                   seg_floor;
   logic [W-1:0]                   segs;
   logic [W-1:0]                   w_min;
   logic [lcw_pkg::ACC_BITS:0]     acc_sum;
   logic [lcw_pkg::ACC_BITS-1:0]   acc_sat;
   logic                           acc_ge_cw;
   logic                           acc_gt_cw;
   logic [INCR_BITS-1:0]           incr_lim;
   logic [INCR_BITS-1:0]           incr_ack;
   logic [SUM_BITS-1:0]            grow_sum;
   logic [W-1:0]                   grow_sat;
   logic [W-1:0]                   shrunk;
   logic [W-1:0]                   shrunk_fl;
   logic                           no_rtt;
   logic                           under_target;
   logic [lcw_pkg::FLIGHT_BITS-1:0] flight_mss;
   logic [lcw_pkg::FIELD_BITS:0]   exit_sum;
   logic [W-1:0]                   exit_sat;

   assign mss = (cfg_mss_ff == '0) ? lcw_pkg::MSS_BITS'(1) : cfg_mss_ff;

   // threshold_in saturates to the window width when it is loaded
   assign thr_ext = (lcw_pkg::FIELD_BITS + 1)'(req_threshold_in);
   assign thr_sat = ((thr_ext >> W) != '0) ? WIN_MAX : thr_ext[W-1:0];

   assign prod_sat = (prod_ff[PROD_BITS-1:W] != '0) ? WIN_MAX : prod_ff[W-1:0];

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_target_ff  <= lcw_pkg::TARGET_DELAY_RST;
         cfg_allowed_ff <= lcw_pkg::ALLOWED_INC_RST;
         cfg_shift_ff   <= lcw_pkg::TETHER_SHIFT_RST;
         cfg_init_ff    <= lcw_pkg::INIT_WINDOW_RST;
         cfg_mss_ff     <= lcw_pkg::MSS_RST;
         cfg_abc_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (lcw_pkg::lcw_csr_type'(csr_index))
            lcw_pkg::CSR_TARGET_DELAY: cfg_target_ff  <= csr_wdata;
            lcw_pkg::CSR_ALLOWED_INC:  cfg_allowed_ff <= csr_wdata[lcw_pkg::SEGS_BITS-1:0];
            lcw_pkg::CSR_TETHER_SHIFT: cfg_shift_ff   <= csr_wdata[lcw_pkg::SHIFT_BITS-1:0];
            lcw_pkg::CSR_INIT_WINDOW:  cfg_init_ff    <= csr_wdata[lcw_pkg::SEGS_BITS-1:0];
            lcw_pkg::CSR_MSS:          cfg_mss_ff     <= csr_wdata;
            lcw_pkg::CSR_ABC_DOUBLE:   cfg_abc_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- request capture ----------------
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         act_ff    <= lcw_pkg::lcw_action_type'(req_action);
         acked_ff  <= req_bytes_acked;
         base_ff   <= req_base_rtt;
         cur_ff    <= req_current_rtt;
         flight_ff <= req_bytes_in_flight;
         peer_ff   <= req_peer_window;
         atmax_ff  <= req_at_send_max;
         estab_ff  <= req_established;
         thr_ff    <= thr_sat;
      end
   end

   // ---------------- shared divider ----------------
   assign w_min = (peer_ff < lcw_pkg::FIELD_BITS'(cong_ff)) ? peer_ff[W-1:0] : cong_ff;
   assign div_dividend = (act_ff == lcw_pkg::ACT_SWITCH && cong_ff > bg_ff) ?
                         w_min : (w_min >> 1);

   lcw_div #(
      .WIDTH (W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (mss),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ---------------- shared multiplier operand ----------------
   assign seg_floor = (act_ff == lcw_pkg::ACT_SWITCH) ? W'(cfg_init_ff) :
                      W'(lcw_pkg::MIN_HALVE_SEGS);
   assign segs      = (div_quot < seg_floor) ? seg_floor : div_quot;

   always_comb begin
      case (state_ff)
         lcw_pkg::ST_FLOOR_MUL: mul_a = W'(cfg_init_ff);
         lcw_pkg::ST_CAP_MUL:   mul_a = W'(cfg_allowed_ff);
         default:               mul_a = segs;
      endcase
   end

   assign prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mss);

   // ---------------- ack bookkeeping ----------------
   assign acc_sum   = (lcw_pkg::ACC_BITS + 1)'(acc_ff) + (lcw_pkg::ACC_BITS + 1)'(acked_ff);
   assign acc_sat   = acc_sum[lcw_pkg::ACC_BITS] ? {lcw_pkg::ACC_BITS{1'b1}} :
                      acc_sum[lcw_pkg::ACC_BITS-1:0];
   assign acc_ge_cw = acc_ff >= lcw_pkg::ACC_BITS'(cong_ff);
   assign acc_gt_cw = acc_ff >  lcw_pkg::ACC_BITS'(cong_ff);

   assign incr_lim  = (cfg_abc_ff && atmax_ff) ? (INCR_BITS'(mss) << 1) : INCR_BITS'(mss);
   always_comb begin
      if (cong_ff >= bg_ff)
         incr_ack = acc_ge_cw ? INCR_BITS'(mss) : '0;
      else if (acked_ff < lcw_pkg::FIELD_BITS'(incr_lim))
         incr_ack = acked_ff[INCR_BITS-1:0];
      else
         incr_ack = incr_lim;
   end

   always_comb begin
      case (act_ff)
         lcw_pkg::ACT_ACK:      exec_grow = (incr_ack != '0);
         lcw_pkg::ACT_FAST_ACK: exec_grow = acc_gt_cw &&
                                            (lcw_pkg::FIELD_BITS'(cong_ff) < peer_ff);
         default:               exec_grow = 1'b0;
      endcase
   end

   // ---------------- growth step ----------------
   assign grow_sum  = SUM_BITS'(cong_ff) + SUM_BITS'(incr_ff);
   assign grow_sat  = (grow_sum[SUM_BITS-1:W] != '0) ? WIN_MAX : grow_sum[W-1:0];
   assign shrunk    = cong_ff - (cong_ff >> 3);
   assign shrunk_fl = (shrunk < floor_ff) ? floor_ff : shrunk;
   assign no_rtt    = (base_ff == '0) || (cur_ff == '0);
   // queuing delay cur - base at or under target; negative delay counts as under
   assign under_target = (lcw_pkg::RTT_BITS + 1)'(cur_ff) <=
                         (lcw_pkg::RTT_BITS + 1)'(base_ff) + (lcw_pkg::RTT_BITS + 1)'(cfg_target_ff);

   // ---------------- exit recovery ----------------
   assign flight_mss = (flight_ff > lcw_pkg::FLIGHT_BITS'(mss)) ? flight_ff :
                       lcw_pkg::FLIGHT_BITS'(mss);
   assign exit_sum   = (lcw_pkg::FIELD_BITS + 1)'(flight_mss) + (lcw_pkg::FIELD_BITS + 1)'(mss);
   assign exit_sat   = ((exit_sum >> W) != '0) ? WIN_MAX : exit_sum[W-1:0];

   // ---------------- datapath next values ----------------
   always_comb begin
      cong_in     = cong_ff;
      slow_in     = slow_ff;
      bg_in       = bg_ff;
      acc_in      = acc_ff;
      incr_in     = incr_ff;
      floor_in    = floor_ff;
      cap_in      = cap_ff;
      rsp_win_in  = rsp_win_ff;
      rsp_slow_in = rsp_slow_ff;
      rsp_bg_in   = rsp_bg_ff;
      case (state_ff)
         lcw_pkg::ST_ACC: begin
            acc_in = acc_sat;
         end
         lcw_pkg::ST_EXEC: begin
            case (act_ff)
               lcw_pkg::ACT_ACK: begin
                  incr_in = incr_ack;
                  if (acc_ge_cw)
                     acc_in = acc_ff - lcw_pkg::ACC_BITS'(cong_ff);
               end
               lcw_pkg::ACT_FAST_ACK: begin
                  incr_in = INCR_BITS'(mss);
                  if (acc_gt_cw)
                     acc_in = acc_ff - lcw_pkg::ACC_BITS'(cong_ff);
               end
               lcw_pkg::ACT_EXIT_RECOVERY: begin
                  if (lcw_pkg::FIELD_BITS'(flight_ff) < lcw_pkg::FIELD_BITS'(slow_ff))
                     cong_in = exit_sat;
                  else
                     cong_in = slow_ff;
                  acc_in = '0;
               end
               lcw_pkg::ACT_SWITCH: begin
                  slow_in = thr_ff;
                  if (bg_ff == '0 || bg_ff > thr_ff)
                     bg_in = thr_ff;
               end
               default: ;
            endcase
         end
         lcw_pkg::ST_FLOOR_APPLY: begin
            cong_in = prod_sat;
            if (act_ff == lcw_pkg::ACT_INIT) begin
               slow_in = thr_ff;
               bg_in   = thr_ff;
            end
         end
         lcw_pkg::ST_CAP_MUL: begin
            floor_in = prod_sat;
         end
         lcw_pkg::ST_GROW: begin
            if (no_rtt) begin
               cong_in = grow_sat;
            end else if (under_target) begin
               if (bg_ff < cong_ff)
                  bg_in = cong_ff;
               cong_in = grow_sat;
            end else begin
               cong_in = shrunk_fl;
               if (bg_ff > shrunk_fl)
                  bg_in = shrunk_fl;
            end
            // tether cap: allowed segments plus scaled flight size
            cap_in = CAP_BITS'(prod_ff[lcw_pkg::SMALL_PROD_BITS-1:0]) +
                     (CAP_BITS'(flight_ff) << cfg_shift_ff);
         end
         lcw_pkg::ST_CAP: begin
            if (CAP_BITS'(cong_ff) > cap_ff)
               cong_in = cap_ff[W-1:0];
         end
         lcw_pkg::ST_SEG_APPLY: begin
            if (act_ff == lcw_pkg::ACT_SWITCH) begin
               cong_in = prod_sat;
               acc_in  = '0;
            end else begin
               slow_in = prod_sat;
               if (bg_ff > prod_sat)
                  bg_in = prod_sat;
               if (act_ff == lcw_pkg::ACT_TIMEOUT)
                  cong_in = W'(mss);
            end
         end
         lcw_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_win_in  = cong_ff;
               rsp_slow_in = slow_ff;
               rsp_bg_in   = bg_ff;
            end
         end
         default: ;
      endcase
   end

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcw_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (lcw_pkg::lcw_action_type'(req_action)) inside
                  lcw_pkg::ACT_INIT, lcw_pkg::ACT_IDLE_RESTART:
                     state_in = lcw_pkg::ST_FLOOR_MUL;
                  lcw_pkg::ACT_ACK, lcw_pkg::ACT_FAST_ACK:
                     state_in = lcw_pkg::ST_ACC;
                  lcw_pkg::ACT_ENTER_RECOVERY:
                     state_in = lcw_pkg::ST_DIV_SET;
                  default:
                     state_in = lcw_pkg::ST_EXEC;
               endcase
            end
         end
         lcw_pkg::ST_ACC:  state_in = lcw_pkg::ST_EXEC;
         lcw_pkg::ST_EXEC: begin
            unique case (act_ff) inside
               lcw_pkg::ACT_ACK, lcw_pkg::ACT_FAST_ACK:
                  state_in = exec_grow ? lcw_pkg::ST_FLOOR_MUL : lcw_pkg::ST_DONE;
               lcw_pkg::ACT_TIMEOUT:
                  state_in = estab_ff ? lcw_pkg::ST_DIV_SET : lcw_pkg::ST_DONE;
               lcw_pkg::ACT_SWITCH:
                  state_in = lcw_pkg::ST_DIV_SET;
               default:
                  state_in = lcw_pkg::ST_DONE;
            endcase
         end
         lcw_pkg::ST_FLOOR_MUL: begin
            if (act_ff == lcw_pkg::ACT_ACK || act_ff == lcw_pkg::ACT_FAST_ACK)
               state_in = lcw_pkg::ST_CAP_MUL;
            else
               state_in = lcw_pkg::ST_FLOOR_APPLY;
         end
         lcw_pkg::ST_FLOOR_APPLY: state_in = lcw_pkg::ST_DONE;
         lcw_pkg::ST_CAP_MUL:     state_in = lcw_pkg::ST_GROW;
         lcw_pkg::ST_GROW:        state_in = lcw_pkg::ST_CAP;
         lcw_pkg::ST_CAP:         state_in = lcw_pkg::ST_DONE;
         lcw_pkg::ST_DIV_SET:     state_in = lcw_pkg::ST_DIV_WAIT;
         lcw_pkg::ST_DIV_WAIT: begin
            if (div_done)
               state_in = lcw_pkg::ST_SEG_MUL;
         end
         lcw_pkg::ST_SEG_MUL:     state_in = lcw_pkg::ST_SEG_APPLY;
         lcw_pkg::ST_SEG_APPLY:   state_in = lcw_pkg::ST_DONE;
         lcw_pkg::ST_DONE: begin
            if (rsp_load)
               state_in = lcw_pkg::ST_IDLE;
         end
         default: state_in = lcw_pkg::ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_ready = (state_ff == lcw_pkg::ST_IDLE);
      div_start = (state_ff == lcw_pkg::ST_DIV_SET);
      rsp_load  = (state_ff == lcw_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcw_pkg::ST_IDLE;
         cong_ff      <= '0;
         slow_ff      <= WIN_MAX;
         bg_ff        <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cong_ff      <= cong_in;
         slow_ff      <= slow_in;
         bg_ff        <= bg_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      incr_ff     <= incr_in;
      floor_ff    <= floor_in;
      cap_ff      <= cap_in;
      prod_ff     <= prod_in;
      rsp_win_ff  <= rsp_win_in;
      rsp_slow_ff <= rsp_slow_in;
      rsp_bg_ff   <= rsp_bg_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_window               = lcw_pkg::FIELD_BITS'(rsp_win_ff);
   assign rsp_threshold            = lcw_pkg::FIELD_BITS'(rsp_slow_ff);
   assign rsp_background_threshold = lcw_pkg::FIELD_BITS'(rsp_bg_ff);

endmodule

[rtl/lcw_div.sv]
// ---------------------------------------------------------------------------
// lcw_div
// Restoring divider of a window value by the segment size, one quotient
// bit per cycle. done pulses for one cycle when quotient is final.
// ---------------------------------------------------------------------------
module lcw_div #(
   parameter int WIDTH = lcw_pkg::WINDOW_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [WIDTH-1:0]             dividend,
   input  logic [lcw_pkg::MSS_BITS-1:0] divisor,
   output logic                         done,
   output logic [WIDTH-1:0]             quotient
);

   localparam int CNT_BITS = $clog2(WIDTH + 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic [lcw_pkg::MSS_BITS-1:0] rem_ff, rem_in;
   logic [lcw_pkg::MSS_BITS-1:0] dsr_ff, dsr_in;
   logic [WIDTH-1:0]             quo_ff, quo_in;

   logic [lcw_pkg::MSS_BITS:0]   trial;
   logic [lcw_pkg::MSS_BITS:0]   diff;
   logic                         fits;

   assign trial = {rem_ff, quo_ff[WIDTH-1]};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(WIDTH);
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[lcw_pkg::MSS_BITS-1:0] : trial[lcw_pkg::MSS_BITS-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/lcw_checker.sv]
// ---------------------------------------------------------------------------
// lcw_checker
// Port-level checks of the congestion window core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lcw_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [lcw_pkg::FIELD_BITS-1:0]     rsp_window,
   input logic [lcw_pkg::FIELD_BITS-1:0]     rsp_threshold,
   input logic [lcw_pkg::FIELD_BITS-1:0]     rsp_background_threshold
);

   // one request in flight: ready drops right after an accept
   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "ready high after accept")

   // reset leaves the core idle with no stale response
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (req_ready && !rsp_valid), "not idle after reset")

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_window) && $stable(rsp_threshold) && $stable(rsp_background_threshold), "response changed while stalled")

endmodule

bind ledbat_congestion_window_core lcw_checker u_lcw_checker (.*);
